[hdl/cdsr_pkg.sv]
// Shared types, codes and frame packing helpers for the CAN diagnostic responder.
package cdsr_pkg;

    localparam logic [10:0] FUNC_ID   = 11'h7DF;
    localparam logic [10:0] RESP_BASE = 11'h780;

    localparam logic [7:0] SID_SESSION = 8'h10;
    localparam logic [7:0] SID_READ    = 8'h22;
    localparam logic [7:0] SID_WRITE   = 8'h2E;
    localparam logic [7:0] POS_OFFSET  = 8'h40;
    localparam logic [7:0] NEG_MARK    = 8'h7F;

    localparam logic [7:0] NRC_WRONG_FORMAT    = 8'h13;
    localparam logic [7:0] NRC_OUT_OF_RANGE    = 8'h12;
    localparam logic [7:0] NRC_SERVICE_UNKNOWN = 8'h11;

    localparam logic [7:0] SUB_EXIT   = 8'h00;
    localparam logic [7:0] SUB_OPEN   = 8'h02;
    localparam logic [7:0] SUB_ASSIGN = 8'h05;

    localparam logic [15:0] PID_SERIAL = 16'd1;
    localparam logic [15:0] PID_NODE   = 16'd2;
    localparam logic [15:0] PID_GAIN0  = 16'd3;
    localparam logic [15:0] PID_GAIN1  = 16'd4;
    localparam logic [15:0] PID_GAIN2  = 16'd5;
    localparam logic [15:0] PID_LIMIT  = 16'd6;
    localparam logic [15:0] PID_BUS_ID = 16'd7;
    localparam logic [15:0] PID_STATUS = 16'd8;

    localparam logic [7:0] LEN_SHORT  = 8'd3;
    localparam logic [7:0] LEN_BYTE   = 8'd4;
    localparam logic [7:0] LEN_HALF   = 8'd5;
    localparam logic [7:0] LEN_WORD   = 8'd7;

    typedef struct packed {
        logic [10:0] rx_id;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [7:0]  b5;
        logic [7:0]  b6;
        logic [7:0]  b7;
    } frame_t;

    typedef struct packed {
        logic             session_open;
        logic [31:0]      serial_number;
        logic [7:0]       node_id;
        logic [2:0][31:0] gain_words;
        logic [31:0]      limit_word;
        logic [15:0]      bus_id_setting;
        logic [1:0][7:0]  cycle_status;
    } state_t;

    typedef struct packed {
        logic [10:0] tx_id;
        logic [63:0] tx_data;
        logic        store_update;
    } result_t;

    // Length, reply service and a 16-bit identifier sent high byte first.
    function automatic logic [63:0] pack_head(input logic [7:0] len, input logic [7:0] rsid,
                                              input logic [15:0] pid);
        pack_head = {32'd0, pid[7:0], pid[15:8], rsid, len};
    endfunction

    function automatic logic [63:0] pack_neg(input logic [7:0] sid, input logic [7:0] code);
        pack_neg = {32'd0, code, sid, NEG_MARK, LEN_SHORT};
    endfunction

endpackage

[hdl/cdsr_decode.sv]
// Single-pass service decode: builds the response and the next parameter table.
module cdsr_decode (
    input  cdsr_pkg::frame_t  frame,
    input  cdsr_pkg::state_t  state_cur,
    output cdsr_pkg::state_t  state_next,
    output cdsr_pkg::result_t result,
    output logic              result_valid
);
    import cdsr_pkg::*;

    logic        functional;
    logic [15:0] pid;
    logic [31:0] word;
    logic [63:0] data;
    logic        upd;
    logic [7:0]  rsid;

    assign functional = (frame.rx_id == FUNC_ID);
    assign pid        = {frame.b2, frame.b3};
    assign word       = {frame.b7, frame.b6, frame.b5, frame.b4};
    assign rsid       = frame.b1 + POS_OFFSET;

    always_comb
    begin
        state_next   = state_cur;
        result_valid = 1'b0;
        data         = '0;
        upd          = 1'b0;

        if (frame.b0[7:4] != 4'd0)
        begin
            result_valid = 1'b1;
            data         = pack_neg(frame.b1, NRC_WRONG_FORMAT);
        end
        else
        begin
            case (frame.b1)
                SID_SESSION:
                begin
                    if (state_cur.session_open && frame.b2 == SUB_EXIT)
                    begin
                        state_next.session_open = 1'b0;
                        result_valid = 1'b1;
                        data = pack_head(LEN_SHORT, rsid, {8'd0, state_cur.node_id});
                    end
                    else if (frame.b2 == SUB_OPEN && !functional)
                    begin
                        state_next.session_open = 1'b1;
                        result_valid = 1'b1;
                        data = pack_head(LEN_WORD, rsid, {8'd0, state_cur.node_id})
                             | {state_cur.serial_number, 32'd0};
                    end
                    else if (frame.b2 == SUB_ASSIGN && word == state_cur.serial_number)
                    begin
                        // Node id assignment answers with the freshly assigned id.
                        state_next.session_open = 1'b1;
                        state_next.node_id      = frame.b3;
                        result_valid = 1'b1;
                        upd          = 1'b1;
                        data = pack_head(LEN_WORD, rsid, {8'd0, frame.b3})
                             | {state_cur.serial_number, 32'd0};
                    end
                end
                SID_READ:
                begin
                    result_valid = 1'b1;
                    case (pid)
                        PID_SERIAL: data = pack_head(LEN_WORD, rsid, pid)
                                         | {state_cur.serial_number, 32'd0};
                        PID_NODE:   data = pack_head(LEN_BYTE, rsid, pid)
                                         | {24'd0, state_cur.node_id, 32'd0};
                        PID_GAIN0:  data = pack_head(LEN_WORD, rsid, pid)
                                         | {state_cur.gain_words[0], 32'd0};
                        PID_GAIN1:  data = pack_head(LEN_WORD, rsid, pid)
                                         | {state_cur.gain_words[1], 32'd0};
                        PID_GAIN2:  data = pack_head(LEN_WORD, rsid, pid)
                                         | {state_cur.gain_words[2], 32'd0};
                        PID_LIMIT:  data = pack_head(LEN_WORD, rsid, pid)
                                         | {state_cur.limit_word, 32'd0};
                        PID_BUS_ID: data = pack_head(LEN_HALF, rsid, pid)
                                         | {16'd0, state_cur.bus_id_setting, 32'd0};
                        PID_STATUS: data = pack_head(LEN_WORD, rsid, pid)
                                         | {16'd0, state_cur.cycle_status[1],
                                            state_cur.cycle_status[0], 32'd0};
                        default:    data = pack_neg(frame.b1, NRC_OUT_OF_RANGE);
                    endcase
                end
                SID_WRITE:
                begin
                    // Functional writes outside a session are dropped without reply.
                    if (state_cur.session_open || !functional)
                    begin
                        result_valid = 1'b1;
                        upd          = 1'b1;
                        data         = pack_head(LEN_SHORT, rsid, pid);
                        case (pid)
                            PID_SERIAL: state_next.serial_number  = word;
                            PID_NODE:   state_next.node_id        = frame.b4;
                            PID_GAIN0:  state_next.gain_words[0]  = word;
                            PID_GAIN1:  state_next.gain_words[1]  = word;
                            PID_GAIN2:  state_next.gain_words[2]  = word;
                            PID_LIMIT:  state_next.limit_word     = word;
                            PID_BUS_ID: state_next.bus_id_setting = {frame.b5, frame.b4};
                            PID_STATUS:
                            begin
                                state_next.cycle_status[0] = frame.b4;
                                state_next.cycle_status[1] = frame.b5;
                            end
                            default:
                            begin
                                upd  = 1'b0;
                                data = pack_neg(frame.b1, NRC_OUT_OF_RANGE);
                            end
                        endcase
                    end
                end
                default:
                begin
                    if (!functional)
                    begin
                        result_valid = 1'b1;
                        data         = pack_neg(frame.b1, NRC_SERVICE_UNKNOWN);
                    end
                end
            endcase
        end

        result.tx_id        = RESP_BASE + {3'd0, state_next.node_id};
        result.tx_data      = data;
        result.store_update = upd;
    end

endmodule

[hdl/can_diag_service_responder_unit.sv]
// Top level of the CAN diagnostic responder: frame register, decode and response register.
// The responder takes one received CAN frame per clock unless stalled, and answers with
// at most one response frame. A frame goes into an input register, is decoded in a single
// pass against the parameter table, and its response (if any) is registered in the output
// register. The parameter table and session flag are read and updated in the same
// cycle as the decode, so back-to-back frames see each other's updates in order. A frame
// leaves the input register only when the output register is empty or being emptied, so a
// stalled consumer holds the pipeline; requests that yield no response simply leave the
// pipeline. After reset the parameter table, node id and session flag are all zero.
module can_diag_service_responder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [10:0] rx_id,
    input  logic [7:0]  rx_byte0,
    input  logic [7:0]  rx_byte1,
    input  logic [7:0]  rx_byte2,
    input  logic [7:0]  rx_byte3,
    input  logic [7:0]  rx_byte4,
    input  logic [7:0]  rx_byte5,
    input  logic [7:0]  rx_byte6,
    input  logic [7:0]  rx_byte7,
    output logic        tx_valid,
    input  logic        tx_ready,
    output logic [10:0] tx_id,
    output logic [63:0] tx_data,
    output logic        store_update
);
    import cdsr_pkg::*;

    logic    frame_valid_reg;
    frame_t  frame_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    logic    res_valid;
    logic    tx_valid_reg;
    result_t tx_reg;
    logic    advance;

    assign advance  = !tx_valid_reg || tx_ready;
    assign rx_ready = !frame_valid_reg || advance;

    cdsr_decode u_decode (
        .frame        (frame_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .result       (res_next),
        .result_valid (res_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            tx_valid_reg    <= 1'b0;
            state_reg       <= '0;
        end
        else
        begin
            if (rx_ready)
            begin
                frame_valid_reg <= rx_valid;
            end
            if (advance)
            begin
                tx_valid_reg <= frame_valid_reg && res_valid;
                if (frame_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
        begin
            frame_reg <= '{rx_id: rx_id, b0: rx_byte0, b1: rx_byte1, b2: rx_byte2,
                           b3: rx_byte3, b4: rx_byte4, b5: rx_byte5, b6: rx_byte6,
                           b7: rx_byte7};
        end
        if (advance && frame_valid_reg && res_valid)
        begin
            tx_reg <= res_next;
        end
    end

    assign tx_valid     = tx_valid_reg;
    assign tx_id        = tx_reg.tx_id;
    assign tx_data      = tx_reg.tx_data;
    assign store_update = tx_reg.store_update;

endmodule

[hdl/cdsr_checker.sv]
// Port-level checker for the CAN diagnostic responder, bound to the top level.
module cdsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tx_valid,
    input logic        tx_ready,
    input logic [10:0] tx_id,
    input logic [63:0] tx_data,
    input logic        store_update
);
    import cdsr_pkg::*;

    // A held response transaction keeps its contents.
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_data) && $stable(tx_id)
                                  && $stable(store_update))
        else $error("response changed while stalled");

    // Negative replies are three bytes long and never ask for a save.
    a_neg_form: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_data[15:8] == NEG_MARK |->
            tx_data[7:0] == LEN_SHORT && tx_data[63:32] == 32'd0 && !store_update)
        else $error("malformed negative response");

    // Only a positive write or a node id assignment asks for a save.
    a_update_src: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && store_update |->
            tx_data[15:8] == (SID_WRITE + POS_OFFSET)
            || tx_data[15:8] == (SID_SESSION + POS_OFFSET))
        else $error("save request on a response that changes nothing");

    // Every positive write reply asks for a save.
    a_write_saves: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_data[15:8] == (SID_WRITE + POS_OFFSET) |-> store_update)
        else $error("positive write response without save request");

endmodule

bind can_diag_service_responder_unit cdsr_checker u_cdsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tx_valid     (tx_valid),
    .tx_ready     (tx_ready),
    .tx_id        (tx_id),
    .tx_data      (tx_data),
    .store_update (store_update)
);

[tb/sv/tb_can_diag_service_responder_unit.sv]
// Self-checking testbench for the CAN diagnostic responder unit.
module tb_can_diag_service_responder_unit;
    import cdsr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_ready;
    logic [10:0] rx_id;
    logic [7:0]  rx_byte0;
    logic [7:0]  rx_byte1;
    logic [7:0]  rx_byte2;
    logic [7:0]  rx_byte3;
    logic [7:0]  rx_byte4;
    logic [7:0]  rx_byte5;
    logic [7:0]  rx_byte6;
    logic [7:0]  rx_byte7;
    logic        tx_valid;
    logic        tx_ready;
    logic [10:0] tx_id;
    logic [63:0] tx_data;
    logic        store_update;

    // Predicted copy of the responder's session flag and parameter table.
    logic        sess_open;
    logic [31:0] serial_no;
    logic [7:0]  node_no;
    logic [31:0] gain_tbl [3];
    logic [31:0] limit_val;
    logic [15:0] bus_id_val;
    logic [7:0]  cyc_status [2];

    result_t pending_replies [$];
    int      mismatch_count;
    bit      gaps_on;
    bit      stalls_on;

    can_diag_service_responder_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_id        (rx_id),
        .rx_byte0     (rx_byte0),
        .rx_byte1     (rx_byte1),
        .rx_byte2     (rx_byte2),
        .rx_byte3     (rx_byte3),
        .rx_byte4     (rx_byte4),
        .rx_byte5     (rx_byte5),
        .rx_byte6     (rx_byte6),
        .rx_byte7     (rx_byte7),
        .tx_valid     (tx_valid),
        .tx_ready     (tx_ready),
        .tx_id        (tx_id),
        .tx_data      (tx_data),
        .store_update (store_update)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("FAIL can_diag_service_responder_unit");
        $finish;
    end

    function automatic frame_t make_frame(input logic [10:0] id, input logic [7:0] b0,
                                          input logic [7:0] sid, input logic [7:0] b2,
                                          input logic [7:0] b3, input logic [31:0] word);
        frame_t f;
        f.rx_id = id;
        f.b0 = b0;
        f.b1 = sid;
        f.b2 = b2;
        f.b3 = b3;
        {f.b7, f.b6, f.b5, f.b4} = word;
        return f;
    endfunction

    // Positive reply: length, reply service, identifier high then low, four data bytes.
    function automatic logic [63:0] pos_reply(input logic [7:0] len, input logic [7:0] rsid,
                                              input logic [15:0] pid, input logic [31:0] val);
        logic [7:0] rb [8];
        rb[0] = len;
        rb[1] = rsid;
        rb[2] = pid[15:8];
        rb[3] = pid[7:0];
        {rb[7], rb[6], rb[5], rb[4]} = val;
        return {rb[7], rb[6], rb[5], rb[4], rb[3], rb[2], rb[1], rb[0]};
    endfunction

    function automatic logic [63:0] neg_reply(input logic [7:0] sid, input logic [7:0] code);
        logic [63:0] d;
        d = '0;
        d[7:0]   = LEN_SHORT;
        d[15:8]  = NEG_MARK;
        d[23:16] = sid;
        d[31:24] = code;
        return d;
    endfunction

    // Applies one request to the predicted table; returns 1 when a reply is due.
    function automatic bit predict_reply(input frame_t f, output result_t r);
        logic [15:0] pid;
        logic [31:0] word;
        logic [63:0] data;
        logic [7:0]  rsid;
        bit          functional;
        bit          due;
        bit          upd;
        functional = (f.rx_id == FUNC_ID);
        pid = {f.b2, f.b3};
        word = {f.b7, f.b6, f.b5, f.b4};
        rsid = f.b1 + POS_OFFSET;
        data = '0;
        due = 1'b0;
        upd = 1'b0;
        if (f.b0[7:4] != 4'd0)
        begin
            due = 1'b1;
            data = neg_reply(f.b1, NRC_WRONG_FORMAT);
        end
        else if (f.b1 == SID_SESSION)
        begin
            if (sess_open && f.b2 == SUB_EXIT)
            begin
                sess_open = 1'b0;
                due = 1'b1;
                data = pos_reply(LEN_SHORT, rsid, {8'd0, node_no}, 32'd0);
            end
            else if (f.b2 == SUB_OPEN && !functional)
            begin
                sess_open = 1'b1;
                due = 1'b1;
                data = pos_reply(LEN_WORD, rsid, {8'd0, node_no}, serial_no);
            end
            else if (f.b2 == SUB_ASSIGN && word == serial_no)
            begin
                sess_open = 1'b1;
                node_no = f.b3;
                due = 1'b1;
                upd = 1'b1;
                data = pos_reply(LEN_WORD, rsid, {8'd0, node_no}, serial_no);
            end
        end
        else if (f.b1 == SID_READ)
        begin
            due = 1'b1;
            case (pid)
                PID_SERIAL: data = pos_reply(LEN_WORD, rsid, pid, serial_no);
                PID_NODE:   data = pos_reply(LEN_BYTE, rsid, pid, {24'd0, node_no});
                PID_GAIN0, PID_GAIN1, PID_GAIN2:
                    data = pos_reply(LEN_WORD, rsid, pid, gain_tbl[pid - PID_GAIN0]);
                PID_LIMIT:  data = pos_reply(LEN_WORD, rsid, pid, limit_val);
                PID_BUS_ID: data = pos_reply(LEN_HALF, rsid, pid, {16'd0, bus_id_val});
                PID_STATUS:
                    data = pos_reply(LEN_WORD, rsid, pid,
                                     {16'd0, cyc_status[1], cyc_status[0]});
                default:    data = neg_reply(f.b1, NRC_OUT_OF_RANGE);
            endcase
        end
        else if (f.b1 == SID_WRITE)
        begin
            if (sess_open || !functional)
            begin
                due = 1'b1;
                upd = 1'b1;
                case (pid)
                    PID_SERIAL: serial_no = word;
                    PID_NODE:   node_no = f.b4;
                    PID_GAIN0, PID_GAIN1, PID_GAIN2: gain_tbl[pid - PID_GAIN0] = word;
                    PID_LIMIT:  limit_val = word;
                    PID_BUS_ID: bus_id_val = {f.b5, f.b4};
                    PID_STATUS:
                    begin
                        cyc_status[0] = f.b4;
                        cyc_status[1] = f.b5;
                    end
                    default:    upd = 1'b0;
                endcase
                if (upd)
                    data = pos_reply(LEN_SHORT, rsid, pid, 32'd0);
                else
                    data = neg_reply(f.b1, NRC_OUT_OF_RANGE);
            end
        end
        else if (!functional)
        begin
            due = 1'b1;
            data = neg_reply(f.b1, NRC_SERVICE_UNKNOWN);
        end
        // The reply identifier follows the node id after this request's update.
        r.tx_id = RESP_BASE + {3'd0, node_no};
        r.tx_data = data;
        r.store_update = upd;
        return due;
    endfunction

    // Sends one request frame and records the reply it should produce.
    task automatic send_frame(input frame_t f);
        result_t r;
        if (gaps_on)
        begin
            while ($urandom_range(99) < 22)
            begin
                rx_valid <= 1'b0;
                @(posedge clk);
            end
        end
        rx_valid <= 1'b1;
        rx_id    <= f.rx_id;
        rx_byte0 <= f.b0;
        rx_byte1 <= f.b1;
        rx_byte2 <= f.b2;
        rx_byte3 <= f.b3;
        rx_byte4 <= f.b4;
        rx_byte5 <= f.b5;
        rx_byte6 <= f.b6;
        rx_byte7 <= f.b7;
        do
            @(posedge clk);
        while (!rx_ready);
        if (predict_reply(f, r))
            pending_replies.push_back(r);
    endtask

    // Holds the request side until every outstanding reply has been received.
    task automatic drain_replies();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        tx_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tx_ready <= !(stalls_on && $urandom_range(99) < 22);
        end
    end

    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && tx_valid && tx_ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("reply transaction with none expected: tx_id %h tx_data %h",
                           tx_id, tx_data);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (tx_id !== want.tx_id)
                    begin
                        $error("tx_id expected %h actual %h", want.tx_id, tx_id);
                        mismatch_count++;
                    end
                    if (tx_data !== want.tx_data)
                    begin
                        $error("tx_data expected %h actual %h", want.tx_data, tx_data);
                        mismatch_count++;
                    end
                    if (store_update !== want.store_update)
                    begin
                        $error("store_update expected %b actual %b",
                               want.store_update, store_update);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic test_frame_type_errors();
        send_frame(make_frame(11'h7FF, 8'hF0, SID_READ, 8'h00, 8'h01, 32'd0));
        send_frame(make_frame(FUNC_ID, 8'h18, 8'hFF, 8'h00, 8'h00, 32'd0));
    endtask

    task automatic test_session_control();
        send_frame(make_frame(11'h000, 8'h02, SID_SESSION, SUB_EXIT, 8'h00, 32'd0));
        send_frame(make_frame(FUNC_ID, 8'h02, SID_SESSION, SUB_OPEN, 8'h00, 32'd0));
        // Functional write with no session open must be dropped.
        send_frame(make_frame(FUNC_ID, 8'h07, SID_WRITE, 8'h00, 8'h03, 32'hFFFF_FFFF));
        send_frame(make_frame(11'h123, 8'h02, SID_SESSION, SUB_OPEN, 8'h00, 32'd0));
        send_frame(make_frame(11'h123, 8'h07, SID_SESSION, SUB_ASSIGN, 8'h2A, 32'd0));
        send_frame(make_frame(11'h123, 8'h02, SID_SESSION, 8'hFF, 8'h00, 32'd0));
        send_frame(make_frame(11'h123, 8'h02, SID_SESSION, SUB_EXIT, 8'h00, 32'd0));
    endtask

    task automatic test_table_write_read();
        send_frame(make_frame(11'h7FF, 8'h02, SID_SESSION, SUB_OPEN, 8'h00, 32'd0));
        send_frame(make_frame(FUNC_ID, 8'h07, SID_WRITE, 8'h00, 8'h01, 32'hFFFF_FFFF));
        send_frame(make_frame(11'h555, 8'h04, SID_WRITE, 8'h00, 8'h02, 32'h0000_00FF));
        send_frame(make_frame(11'h2AA, 8'h07, SID_WRITE, 8'h00, 8'h03, 32'h1234_5678));
        send_frame(make_frame(11'h2AA, 8'h07, SID_WRITE, 8'h00, 8'h04, 32'h8000_0001));
        send_frame(make_frame(11'h2AA, 8'h07, SID_WRITE, 8'h00, 8'h05, 32'h0000_0000));
        send_frame(make_frame(11'h2AA, 8'h07, SID_WRITE, 8'h00, 8'h06, 32'hDEAD_BEEF));
        send_frame(make_frame(FUNC_ID, 8'h05, SID_WRITE, 8'h00, 8'h07, 32'hAAAA_BEEF));
        send_frame(make_frame(11'h2AA, 8'h05, SID_WRITE, 8'h00, 8'h08, 32'h5555_A55A));
        send_frame(make_frame(11'h001, 8'h03, SID_READ, 8'h00, 8'h02, 32'd0));
        send_frame(make_frame(FUNC_ID, 8'h03, SID_READ, 8'h00, 8'h05, 32'd0));
        send_frame(make_frame(11'h001, 8'h03, SID_READ, 8'h00, 8'h07, 32'd0));
        send_frame(make_frame(11'h001, 8'h03, SID_READ, 8'h00, 8'h08, 32'd0));
        send_frame(make_frame(11'h001, 8'h07, SID_WRITE, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
        send_frame(make_frame(11'h001, 8'h03, SID_READ, 8'h00, 8'h00, 32'd0));
        send_frame(make_frame(FUNC_ID, 8'h07, SID_SESSION, SUB_ASSIGN, 8'h01,
                              32'hFFFF_FFFF));
    endtask

    task automatic test_unknown_requests();
        send_frame(make_frame(11'h000, 8'h01, 8'h00, 8'h00, 8'h00, 32'd0));
        send_frame(make_frame(FUNC_ID, 8'h01, 8'hFF, 8'h00, 8'h00, 32'd0));
    endtask

    // Mostly well-formed requests with random content, plus some noise.
    task automatic test_random_traffic(input int count);
        frame_t      f;
        int          pick;
        logic [15:0] pid;
        for (int n = 0; n < count; n++)
        begin
            f.rx_id = ($urandom_range(99) < 30) ? FUNC_ID : 11'($urandom_range(2047));
            f.b0 = ($urandom_range(99) < 8) ? 8'($urandom) : {4'd0, 4'($urandom)};
            pick = $urandom_range(99);
            if (pick < 30)
                f.b1 = SID_SESSION;
            else if (pick < 60)
                f.b1 = SID_READ;
            else if (pick < 90)
                f.b1 = SID_WRITE;
            else
                f.b1 = 8'($urandom);
            pick = $urandom_range(99);
            if (pick < 85)
                pid = 16'($urandom_range(1, 8));
            else if (pick < 95)
                pid = ($urandom_range(1) == 0) ? 16'd0 : 16'd9;
            else
                pid = 16'($urandom);
            {f.b2, f.b3} = pid;
            pick = $urandom_range(9);
            {f.b7, f.b6, f.b5, f.b4} = (pick == 0) ? 32'd0 :
                                       (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
            if (f.b1 == SID_SESSION)
            begin
                pick = $urandom_range(9);
                if (pick < 3)
                    f.b2 = SUB_EXIT;
                else if (pick < 6)
                    f.b2 = SUB_OPEN;
                else if (pick < 9)
                    f.b2 = SUB_ASSIGN;
                else
                    f.b2 = 8'($urandom);
                f.b3 = 8'($urandom);
                // Node id assignment needs the serial number to match.
                if (f.b2 == SUB_ASSIGN && $urandom_range(99) < 70)
                    {f.b7, f.b6, f.b5, f.b4} = serial_no;
            end
            send_frame(f);
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        rx_valid <= 1'b0;
        rx_id    <= '0;
        rx_byte0 <= '0;
        rx_byte1 <= '0;
        rx_byte2 <= '0;
        rx_byte3 <= '0;
        rx_byte4 <= '0;
        rx_byte5 <= '0;
        rx_byte6 <= '0;
        rx_byte7 <= '0;
        sess_open = 1'b0;
        serial_no = '0;
        node_no = '0;
        gain_tbl = '{32'd0, 32'd0, 32'd0};
        limit_val = '0;
        bus_id_val = '0;
        cyc_status = '{8'd0, 8'd0};
        mismatch_count = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_type_errors();
        test_session_control();
        test_table_write_read();
        test_unknown_requests();
        test_random_traffic(500);
        // A long stretch with neither side idling.
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        test_random_traffic(350);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        drain_replies();
        test_random_traffic(480);

        rx_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS can_diag_service_responder_unit");
        else
            $display("FAIL can_diag_service_responder_unit");
        $finish;
    end

endmodule

[filelist.f]
hdl/cdsr_pkg.sv
hdl/cdsr_decode.sv
hdl/can_diag_service_responder_unit.sv
hdl/cdsr_checker.sv
tb/sv/tb_can_diag_service_responder_unit.sv
